// ----- rtl/motor_encoder_frame_tracker_macros.svh -----
// assertion macros for the motor encoder frame tracker
// used by rtl modules that carry concurrent checks
`ifndef MOTOR_ENCODER_FRAME_TRACKER_MACROS_SVH
`define MOTOR_ENCODER_FRAME_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MET_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/met_pkg.sv -----
// shared types and constants for the motor encoder frame tracker
// no dependencies
package met_pkg;

  // field widths
  localparam int ID_W      = 11;
  localparam int ENC_W     = 13;
  localparam int WORD_W    = 16;
  localparam int RATE_W    = 14;
  localparam int TOTAL_W   = 32;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 3;

  // carried index widths, sized for the largest motor count and tap count
  localparam int MOTOR_W    = 4;
  localparam int SLOT_MAX_W = 6;

  // queue depth between the parts and at the output
  localparam int QUEUE_DEPTH = 2;

  // encoder unwrap limits on the 15-bit step
  localparam logic signed [ENC_W+1:0] DIFF_HALF = 15'sd4096;
  localparam logic signed [ENC_W+1:0] DIFF_FULL = 15'sd8192;

  // speed scale 7500/1024
  localparam int              SPEED_NUM_W = 13;
  localparam logic [SPEED_NUM_W-1:0] SPEED_NUM = 13'd7500;
  localparam int              SPEED_SHIFT = 10;

  // saturating frame counter limit
  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // register reset values
  localparam logic [ID_W-1:0]  CHASSIS_BASE_RST = 11'd513;
  localparam logic [ID_W-1:0]  YAW_ID_RST       = 11'd517;
  localparam logic [ID_W-1:0]  PITCH_ID_RST     = 11'd518;
  localparam logic [ID_W-1:0]  TRIGGER_ID_RST   = 11'd519;
  localparam logic [CNT_W-1:0] CHASSIS_CAL_RST  = 8'd50;
  localparam logic [CNT_W-1:0] TRIGGER_CAL_RST  = 8'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHASSIS_BASE = 3'd0,
    CFG_YAW_ID       = 3'd1,
    CFG_PITCH_ID     = 3'd2,
    CFG_TRIGGER_ID   = 3'd3,
    CFG_SPEED_FILTER = 3'd4,
    CFG_CHASSIS_CAL  = 3'd5,
    CFG_TRIGGER_CAL  = 3'd6
  } met_cfg_e;

  // classified frame handed from front to back
  typedef struct packed {
    logic                     matched;
    logic [MOTOR_W-1:0]       motor;
    logic                     calib;
    logic                     filter;
    logic [SLOT_MAX_W-1:0]    slot;
    logic                     old_valid;
    logic [ENC_W-1:0]         enc;
    logic signed [WORD_W-1:0] spd;
    logic signed [WORD_W-1:0] cur;
  } met_item_t;

  // result request
  typedef struct packed {
    logic                      matched;
    logic [IDX_W-1:0]          motor_index;
    logic                      calibrating;
    logic signed [RATE_W-1:0]  encoder_rate;
    logic signed [TOTAL_W-1:0] turn_total;
    logic signed [TOTAL_W-1:0] position_total;
    logic signed [WORD_W-1:0]  speed_out;
    logic signed [WORD_W-1:0]  current_out;
  } met_result_t;

endpackage

// ----- rtl/motor_encoder_frame_tracker.sv -----
// top level of the motor encoder frame tracker; uses met_pkg, met_front,
// met_fifo and met_back
// throughput: one frame per cycle unless the result queue is full, set by the
// per-motor update of encoder, turn count and history sum in the back execute stage
// reset: config takes its default ids and limits, per-motor state clears; history uses fill counts
module motor_encoder_frame_tracker #(
  parameter int RATE_TAPS      = 8,
  parameter int CHASSIS_MOTORS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [met_pkg::ID_W-1:0]          cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [met_pkg::ID_W-1:0]          frame_id_i,
  input  logic                              from_trigger_bus_i,
  input  logic [met_pkg::ENC_W-1:0]         encoder_word_i,
  input  logic signed [met_pkg::WORD_W-1:0] speed_word_i,
  input  logic signed [met_pkg::WORD_W-1:0] current_word_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              matched_o,
  output logic [met_pkg::IDX_W-1:0]         motor_index_o,
  output logic                              calibrating_o,
  output logic signed [met_pkg::RATE_W-1:0] encoder_rate_o,
  output logic signed [met_pkg::TOTAL_W-1:0] turn_total_o,
  output logic signed [met_pkg::TOTAL_W-1:0] position_total_o,
  output logic signed [met_pkg::WORD_W-1:0] speed_out_o,
  output logic signed [met_pkg::WORD_W-1:0] current_out_o
);

  import met_pkg::*;

  logic        accept;
  met_item_t   front_item, q_item;
  logic        q_empty, q_pop;
  met_result_t back_res, out_res;
  logic        out_full, out_push;

  // a frame request is taken when push is high and full is low
  assign accept = push && !full;

  // front: classify and keep counters
  met_front #(
    .RATE_TAPS      (RATE_TAPS),
    .CHASSIS_MOTORS (CHASSIS_MOTORS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .accept_i           (accept),
    .frame_id_i         (frame_id_i),
    .from_trigger_bus_i (from_trigger_bus_i),
    .encoder_word_i     (encoder_word_i),
    .speed_word_i       (speed_word_i),
    .current_word_i     (current_word_i),
    .item_o             (front_item)
  );

  // queue between front and back
  met_fifo #(
    .WIDTH ($bits(met_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_item),
    .empty_o (q_empty)
  );

  // back: execute and scale
  met_back #(
    .RATE_TAPS      (RATE_TAPS),
    .CHASSIS_MOTORS (CHASSIS_MOTORS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_res_o  (back_res)
  );

  // result queue
  met_fifo #(
    .WIDTH ($bits(met_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  // result fields
  assign matched_o        = out_res.matched;
  assign motor_index_o    = out_res.motor_index;
  assign calibrating_o    = out_res.calibrating;
  assign encoder_rate_o   = out_res.encoder_rate;
  assign turn_total_o     = out_res.turn_total;
  assign position_total_o = out_res.position_total;
  assign speed_out_o      = out_res.speed_out;
  assign current_out_o    = out_res.current_out;

endmodule

// ----- rtl/met_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module met_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/met_fifo.sv -----
// small synchronous fifo with push/full and pop/empty sides
// no dependencies
module met_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/met_front.sv -----
// front part: configuration registers, frame classification, calibration
// counters and history slot bookkeeping; depends on met_pkg
module met_front #(
  parameter int RATE_TAPS      = 8,
  parameter int CHASSIS_MOTORS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [met_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [met_pkg::ID_W-1:0]             cfg_data_i,
  input  logic                                 accept_i,
  input  logic [met_pkg::ID_W-1:0]             frame_id_i,
  input  logic                                 from_trigger_bus_i,
  input  logic [met_pkg::ENC_W-1:0]            encoder_word_i,
  input  logic signed [met_pkg::WORD_W-1:0]    speed_word_i,
  input  logic signed [met_pkg::WORD_W-1:0]    current_word_i,
  output met_pkg::met_item_t                   item_o
);

  import met_pkg::*;

  localparam int NUM    = CHASSIS_MOTORS + 3;
  localparam int MI_W   = $clog2(NUM);
  localparam int SLOT_W = $clog2(RATE_TAPS);
  localparam int FILL_W = $clog2(RATE_TAPS + 1);

  logic [ID_W-1:0]  chassis_base_q, yaw_id_q, pitch_id_q, trigger_id_q;
  logic             filter_q;
  logic [CNT_W-1:0] chassis_cal_q, trigger_cal_q;

  logic [CNT_W-1:0]  cnt_q  [NUM];
  logic [SLOT_W-1:0] slot_q [NUM];
  logic [FILL_W-1:0] fill_q [NUM];

  logic [ID_W:0]     rel;
  logic              chassis_hit, yaw_hit, pitch_hit, trig_hit, matched;
  logic [MI_W-1:0]   motor;
  logic [CNT_W-1:0]  cnt_old, cnt_inc;
  logic              calib, count_upd, hist_upd, old_valid;
  logic [SLOT_W-1:0] slot_old, slot_next;
  logic [FILL_W-1:0] fill_old, fill_next;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chassis_base_q <= CHASSIS_BASE_RST;
      yaw_id_q       <= YAW_ID_RST;
      pitch_id_q     <= PITCH_ID_RST;
      trigger_id_q   <= TRIGGER_ID_RST;
      filter_q       <= 1'b0;
      chassis_cal_q  <= CHASSIS_CAL_RST;
      trigger_cal_q  <= TRIGGER_CAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHASSIS_BASE: chassis_base_q <= cfg_data_i;
        CFG_YAW_ID:       yaw_id_q       <= cfg_data_i;
        CFG_PITCH_ID:     pitch_id_q     <= cfg_data_i;
        CFG_TRIGGER_ID:   trigger_id_q   <= cfg_data_i;
        CFG_SPEED_FILTER: filter_q       <= cfg_data_i[0];
        CFG_CHASSIS_CAL:  chassis_cal_q  <= cfg_data_i[CNT_W-1:0];
        CFG_TRIGGER_CAL:  trigger_cal_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // identifier match, chassis first, then yaw, pitch, trigger
  assign rel         = {1'b0, frame_id_i} - {1'b0, chassis_base_q};
  assign chassis_hit = !rel[ID_W] && (rel[ID_W-1:0] < ID_W'(CHASSIS_MOTORS));
  assign yaw_hit     = !chassis_hit && (frame_id_i == yaw_id_q);
  assign pitch_hit   = !chassis_hit && !yaw_hit && (frame_id_i == pitch_id_q);
  assign trig_hit    = !chassis_hit && !yaw_hit && !pitch_hit &&
                       (frame_id_i == trigger_id_q) && from_trigger_bus_i;
  assign matched     = chassis_hit || yaw_hit || pitch_hit || trig_hit;

  always_comb begin
    motor = '0;
    if (chassis_hit) begin
      motor = rel[MI_W-1:0];
    end else if (yaw_hit) begin
      motor = MI_W'(CHASSIS_MOTORS);
    end else if (pitch_hit) begin
      motor = MI_W'(CHASSIS_MOTORS + 1);
    end else if (trig_hit) begin
      motor = MI_W'(CHASSIS_MOTORS + 2);
    end
  end

  // calibration decision: chassis checks the count before the bump,
  // trigger checks it after
  assign cnt_old   = cnt_q[motor];
  assign cnt_inc   = (cnt_old == CNT_MAX) ? CNT_MAX : cnt_old + CNT_W'(1);
  assign count_upd = chassis_hit || trig_hit;
  assign calib     = chassis_hit ? (cnt_old <= chassis_cal_q)
                                 : (trig_hit && (cnt_inc <= trigger_cal_q));

  // history slot and fill level for the moving average
  assign hist_upd  = matched && !calib && filter_q;
  assign slot_old  = slot_q[motor];
  assign slot_next = (slot_old == SLOT_W'(RATE_TAPS - 1)) ? '0 : slot_old + SLOT_W'(1);
  assign fill_old  = fill_q[motor];
  assign fill_next = (fill_old == FILL_W'(RATE_TAPS)) ? fill_old : fill_old + FILL_W'(1);
  assign old_valid = fill_old > FILL_W'(slot_old);

  // per-motor front state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM; i++) begin
        cnt_q[i]  <= '0;
        slot_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (count_upd) begin
        cnt_q[motor] <= cnt_inc;
      end
      if (hist_upd) begin
        slot_q[motor] <= slot_next;
        fill_q[motor] <= fill_next;
      end
    end
  end

  // classified request to the queue
  always_comb begin
    item_o           = '0;
    item_o.matched   = matched;
    item_o.motor     = MOTOR_W'(motor);
    item_o.calib     = calib;
    item_o.filter    = hist_upd;
    item_o.slot      = SLOT_MAX_W'(slot_old);
    item_o.old_valid = old_valid;
    item_o.enc       = encoder_word_i;
    item_o.spd       = speed_word_i;
    item_o.cur       = current_word_i;
  end

endmodule

// ----- rtl/met_back.sv -----
// back part: per-motor encoder unwrap, turn and history update, then
// position and speed scaling stages; depends on met_pkg, met_ram, macros
`include "motor_encoder_frame_tracker_macros.svh"
module met_back #(
  parameter int RATE_TAPS      = 8,
  parameter int CHASSIS_MOTORS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  met_pkg::met_item_t   q_item_i,
  output logic                 q_pop_o,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output met_pkg::met_result_t out_res_o
);

  import met_pkg::*;

  localparam int NUM        = CHASSIS_MOTORS + 3;
  localparam int MI_W       = $clog2(NUM);
  localparam int SLOT_W     = $clog2(RATE_TAPS);
  localparam int SUM_W      = RATE_W + SLOT_W;
  localparam int MAG_W      = SUM_W - 1;
  localparam int RS         = MAG_W + SLOT_W;
  localparam int PROD_W     = 2 * MAG_W + 1;
  localparam int AVG_W      = RATE_W - 1;
  localparam int SP_W       = AVG_W + SPEED_NUM_W;
  localparam int HIST_AW    = MI_W + SLOT_W;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam logic [MAG_W:0] RECIP =
    (MAG_W + 1)'(((64'd1 << RS) + 64'(RATE_TAPS) - 64'd1) / 64'(RATE_TAPS));

  typedef struct packed {
    logic                      matched;
    logic [IDX_W-1:0]          motor;
    logic                      calib;
    logic signed [RATE_W-1:0]  rate;
    logic signed [TOTAL_W-1:0] turn;
    logic                      derived;
    logic signed [WORD_W-1:0]  raw;
    logic signed [WORD_W-1:0]  cur;
  } pipe_t;

  // per-motor state
  logic [ENC_W-1:0]          enc_now_q [NUM];
  logic [ENC_W-1:0]          off_q     [NUM];
  logic signed [TOTAL_W-1:0] turn_q    [NUM];
  logic signed [SUM_W-1:0]   sum_q     [NUM];
  logic                      der_q     [NUM];
  logic signed [WORD_W-1:0]  raw_q     [NUM];
  logic signed [WORD_W-1:0]  cur_q     [NUM];

  // pipeline stages
  logic                      a_v_q, b_v_q, c_v_q, d_v_q;
  met_item_t                 a_q;
  pipe_t                     b_q, c_q, d_q, b_next;
  logic signed [SUM_W-1:0]   b_sum_q;
  logic [ENC_W-1:0]          b_enc_q, b_off_q;
  logic [TOTAL_W-1:0]        c_pos_q, d_pos_q;
  logic                      c_neg_q, d_neg_q;
  logic [AVG_W-1:0]          c_avg_q;
  logic [WORD_W-1:0]         d_mag_q;

  logic                      adv, exec;
  logic [MI_W-1:0]           m;
  logic signed [ENC_W+1:0]   diff, rate_wide;
  logic signed [RATE_W-1:0]  rate, old_hist;
  logic signed [TOTAL_W-1:0] turn_new;
  logic signed [SUM_W-1:0]   sum_new, b_abs;
  logic                      b_neg;
  logic [MAG_W-1:0]          b_mag;
  logic [PROD_W-1:0]         b_prod;
  logic [TOTAL_W-1:0]        b_pos;
  logic [SP_W-1:0]           c_prod;
  logic [WORD_W-1:0]         c_mag, d_speed;

  logic                      ram_we, ram_re;
  logic [HIST_AW-1:0]        ram_waddr, ram_raddr;
  logic [RATE_W-1:0]         ram_rdata;

  // stall-all handshake: the whole back part waits while stage d holds a result and the output is full
  assign adv        = !(d_v_q && out_full_i);
  assign q_pop_o    = adv && !q_empty_i;
  assign exec       = adv && a_v_q && a_q.matched;
  assign out_push_o = d_v_q && !out_full_i;

  // step history memory, read as a request leaves the queue
  assign ram_re    = q_pop_o;
  assign ram_raddr = {q_item_i.motor[MI_W-1:0], q_item_i.slot[SLOT_W-1:0]};
  assign ram_we    = exec && a_q.filter;
  assign ram_waddr = {a_q.motor[MI_W-1:0], a_q.slot[SLOT_W-1:0]};

  met_ram #(
    .WIDTH (RATE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rate),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // unwrap at half a turn
  assign m    = a_q.motor[MI_W-1:0];
  assign diff = $signed({2'b00, a_q.enc}) - $signed({2'b00, enc_now_q[m]});

  always_comb begin
    if (diff > DIFF_HALF) begin
      rate_wide = diff - DIFF_FULL;
      turn_new  = turn_q[m] - 32'sd1;
    end else if (diff < -DIFF_HALF) begin
      rate_wide = diff + DIFF_FULL;
      turn_new  = turn_q[m] + 32'sd1;
    end else begin
      rate_wide = diff;
      turn_new  = turn_q[m];
    end
  end

  assign rate     = rate_wide[RATE_W-1:0];
  assign old_hist = a_q.old_valid ? ram_rdata : '0;
  assign sum_new  = sum_q[m] + SUM_W'(rate) - SUM_W'(old_hist);

  // snapshot of the motor after this frame
  always_comb begin
    b_next         = '0;
    b_next.matched = a_q.matched;
    b_next.motor   = IDX_W'(a_q.motor);
    b_next.calib   = a_q.calib;
    b_next.rate    = a_q.calib ? '0 : rate;
    b_next.turn    = a_q.calib ? turn_q[m] : turn_new;
    b_next.derived = a_q.calib ? der_q[m] : a_q.filter;
    b_next.raw     = (a_q.calib || a_q.filter) ? raw_q[m] : a_q.spd;
    b_next.cur     = (a_q.calib || a_q.filter) ? cur_q[m] : a_q.cur;
  end

  // per-motor state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM; i++) begin
        enc_now_q[i] <= '0;
        off_q[i]     <= '0;
        turn_q[i]    <= '0;
        sum_q[i]     <= '0;
        der_q[i]     <= 1'b0;
        raw_q[i]     <= '0;
        cur_q[i]     <= '0;
      end
    end else if (exec) begin
      enc_now_q[m] <= a_q.enc;
      if (a_q.calib) begin
        off_q[m] <= a_q.enc;
      end else begin
        turn_q[m] <= turn_new;
        if (a_q.filter) begin
          sum_q[m] <= sum_new;
          der_q[m] <= 1'b1;
        end else begin
          der_q[m] <= 1'b0;
          raw_q[m] <= a_q.spd;
          cur_q[m] <= a_q.cur;
        end
      end
    end
  end

  // stage b: position and average by reciprocal multiply
  assign b_pos  = {b_q.turn[TOTAL_W-ENC_W-1:0], ENC_W'(0)} + TOTAL_W'(b_enc_q)
                  - TOTAL_W'(b_off_q);
  assign b_neg  = b_sum_q[SUM_W-1];
  assign b_abs  = b_neg ? -b_sum_q : b_sum_q;
  assign b_mag  = b_abs[MAG_W-1:0];
  assign b_prod = PROD_W'(b_mag) * PROD_W'(RECIP);

  // stage c: scale by 7500/1024
  assign c_prod = SP_W'(c_avg_q) * SP_W'(SPEED_NUM);
  assign c_mag  = c_prod[SPEED_SHIFT+WORD_W-1:SPEED_SHIFT];

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= q_pop_o;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (q_pop_o) begin
        a_q <= q_item_i;
      end
      b_q     <= b_next;
      b_sum_q <= (a_q.filter && !a_q.calib) ? sum_new : sum_q[m];
      b_enc_q <= a_q.enc;
      b_off_q <= a_q.calib ? a_q.enc : off_q[m];
      c_q     <= b_q;
      c_pos_q <= b_pos;
      c_neg_q <= b_neg;
      c_avg_q <= b_prod[RS+AVG_W-1:RS];
      d_q     <= c_q;
      d_pos_q <= c_pos_q;
      d_neg_q <= c_neg_q;
      d_mag_q <= c_mag;
    end
  end

  // stage d: sign of the averaged speed and result request
  assign d_speed = d_neg_q ? -d_mag_q : d_mag_q;

  always_comb begin
    out_res_o = '0;
    if (d_q.matched) begin
      out_res_o.matched        = 1'b1;
      out_res_o.motor_index    = d_q.motor;
      out_res_o.calibrating    = d_q.calib;
      out_res_o.encoder_rate   = d_q.rate;
      out_res_o.turn_total     = d_q.turn;
      out_res_o.position_total = d_pos_q;
      out_res_o.speed_out      = d_q.derived ? d_speed : d_q.raw;
      out_res_o.current_out    = d_q.cur;
    end
  end

  // checks
  `MET_ASSERT_IMPL(a_rate_range, clk_i, rst_ni, exec && !a_q.calib, (rate >= -14'sd4096) && (rate <= 14'sd4096), "unwrapped step out of half-turn range")
  `MET_ASSERT_IMPL(a_hist_no_clash, clk_i, rst_ni, ram_we && ram_re, ram_waddr != ram_raddr, "history read and write hit one slot")
  `MET_ASSERT_NEXT(a_pipe_move, clk_i, rst_ni, adv && a_v_q, b_v_q, "executed request lost between stages")
  `MET_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, d_v_q && out_full_i, d_v_q && $stable(d_pos_q), "stalled result changed")

endmodule
